FILE: src/ests_pkg.sv
// Package for the energy swing-up torque selector: shared types, register
// indexes, reset values and the constant cosine-table function.
// No dependencies; compiled first.
package ests_pkg;

    typedef enum logic [1:0] {
        MODE_BALANCE = 2'd0,
        MODE_PUMP    = 2'd1,
        MODE_COAST   = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        REG_GRAVITY     = 3'd0,
        REG_PEND_MASS   = 3'd1,
        REG_PEND_LENGTH = 3'd2,
        REG_TORQUE_LIM  = 3'd3,
        REG_SWITCH_THR  = 3'd4,
        REG_COAST_TRQ   = 3'd5
    } reg_idx_t;

    localparam int APB_ADDR_W = 5;

    typedef struct packed {
        logic [15:0]        gravity;
        logic [15:0]        pend_mass;
        logic [15:0]        pend_length;
        logic [14:0]        torque_limit;
        logic [14:0]        switch_threshold;
        logic signed [15:0] coast_torque;
    } cfg_t;

    localparam logic [15:0] RST_GRAVITY     = 16'd2511;
    localparam logic [15:0] RST_PEND_MASS   = 16'd4915;
    localparam logic [15:0] RST_PEND_LENGTH = 16'd9699;
    localparam logic [14:0] RST_TORQUE_LIM  = 15'd4096;
    localparam logic [14:0] RST_SWITCH_THR  = 15'd7301;
    localparam logic [15:0] RST_COAST_TRQ   = 16'd205;

    localparam longint ONE_Q30     = 64'sd1 << 30;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam int     COS_ONE_Q14 = 16384;

    // Quarter-wave cosine entry in Q1.14: Q30 Taylor series in Horner form,
    // rounded half up and clamped to [0, 1.0]. Evaluated at elaboration only.
    function automatic logic [14:0] cos_entry(input int unsigned i,
                                              input int unsigned tbl_bits);
        longint x;
        longint x2;
        longint t;
        longint q;
        int     k;
        x  = longint'((longint'(i) * HALF_PI_Q30) >>> tbl_bits);
        x2 = (x * x) / ONE_Q30;
        t  = ONE_Q30;
        for (k = 0; k < 6; k++)
        begin
            q = (x2 * t) / ONE_Q30;
            case (k)
                0:       t = ONE_Q30 - q / 132;
                1:       t = ONE_Q30 - q / 90;
                2:       t = ONE_Q30 - q / 56;
                3:       t = ONE_Q30 - q / 30;
                4:       t = ONE_Q30 - q / 12;
                default: t = ONE_Q30 - q / 2;
            endcase
        end
        if (t < 0)
        begin
            t = 0;
        end
        if (t > ONE_Q30)
        begin
            t = ONE_Q30;
        end
        return 15'((t + 64'sd32768) / 64'sd65536);
    endfunction

endpackage

FILE: src/ests_if.sv
// Valid/ready channel interfaces for the torque selector: the sample word
// in and the torque word out. Depends on ests_pkg.
interface ests_in_if;
    logic               valid;
    logic               ready;
    logic [15:0]        pend_angle;
    logic signed [15:0] pend_rate;
    logic signed [15:0] balance_torque;

    modport source (output valid, pend_angle, pend_rate, balance_torque, input ready);
    modport sink   (input valid, pend_angle, pend_rate, balance_torque, output ready);
endinterface

interface ests_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [15:0]   drive_torque;
    ests_pkg::mode_t      mode;

    modport source (output valid, drive_torque, mode, input ready);
    modport sink   (input valid, drive_torque, mode, output ready);
endinterface

FILE: src/ests_regs.sv
// APB register file for the torque selector configuration.
// Depends on ests_pkg (cfg_t, register indexes, reset values).
module ests_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ests_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output ests_pkg::cfg_t                    cfg
);

    ests_pkg::cfg_t     cfg_reg;
    ests_pkg::cfg_t     cfg_next;
    ests_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx    = ests_pkg::reg_idx_t'(paddr[ests_pkg::APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                ests_pkg::REG_GRAVITY:     cfg_next.gravity          = pwdata[15:0];
                ests_pkg::REG_PEND_MASS:   cfg_next.pend_mass        = pwdata[15:0];
                ests_pkg::REG_PEND_LENGTH: cfg_next.pend_length      = pwdata[15:0];
                ests_pkg::REG_TORQUE_LIM:  cfg_next.torque_limit     = pwdata[14:0];
                ests_pkg::REG_SWITCH_THR:  cfg_next.switch_threshold = pwdata[14:0];
                ests_pkg::REG_COAST_TRQ:   cfg_next.coast_torque     = pwdata[15:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            ests_pkg::REG_GRAVITY:     prdata = {16'd0, cfg_reg.gravity};
            ests_pkg::REG_PEND_MASS:   prdata = {16'd0, cfg_reg.pend_mass};
            ests_pkg::REG_PEND_LENGTH: prdata = {16'd0, cfg_reg.pend_length};
            ests_pkg::REG_TORQUE_LIM:  prdata = {17'd0, cfg_reg.torque_limit};
            ests_pkg::REG_SWITCH_THR:  prdata = {17'd0, cfg_reg.switch_threshold};
            ests_pkg::REG_COAST_TRQ:   prdata = {16'd0, cfg_reg.coast_torque};
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gravity          <= ests_pkg::RST_GRAVITY;
            cfg_reg.pend_mass        <= ests_pkg::RST_PEND_MASS;
            cfg_reg.pend_length      <= ests_pkg::RST_PEND_LENGTH;
            cfg_reg.torque_limit     <= ests_pkg::RST_TORQUE_LIM;
            cfg_reg.switch_threshold <= ests_pkg::RST_SWITCH_THR;
            cfg_reg.coast_torque     <= ests_pkg::RST_COAST_TRQ;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: src/ests_cos_rom.sv
// Quarter-wave cosine ROM (Q1.14 magnitudes) with registered read.
// Depends on ests_pkg (cos_entry table function).
module ests_cos_rom
#(
    parameter int COS_TABLE_BITS = 8
)
(
    input  logic                      clk,
    input  logic                      en,
    input  logic [COS_TABLE_BITS:0]   idx,
    output logic [14:0]               cos_mag
);

    localparam int TBL_SIZE = (1 << COS_TABLE_BITS) + 1;

    logic [14:0] rom [TBL_SIZE];
    logic [14:0] cos_reg;

    for (genvar gi = 0; gi < TBL_SIZE; gi++)
    begin : g_rom
        assign rom[gi] = ests_pkg::cos_entry(gi, COS_TABLE_BITS);
    end

    // Hold the last word while the pipeline is stalled.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= rom[idx];
        end
    end

    assign cos_mag = cos_reg;

endmodule

FILE: src/energy_swingup_torque_select.sv
// Energy swing-up torque selector, top level: APB registers, a four-stage
// pipeline and the registered output word. Depends on ests_pkg, ests_if,
// ests_regs and ests_cos_rom.
//
// Each input word (pendulum angle, rate, regulator torque) yields exactly one
// output word (drive torque and mode). The block takes one word per clock
// while the output side is not stalled, and each accepted word moves
// through four register stages: angle fold and table index, cosine ROM read
// with rate squaring, the two energy multipliers, then the exact energy
// compare and torque select into the output register. A stall on the output
// holds every stage in place and drops input ready, so nothing is lost or
// repeated. Near upright (angle magnitude below switch_threshold) the
// regulator torque passes through; otherwise the pendulum energy is compared
// at full precision with the upright energy and the block either pumps with
// +/- torque_limit or coasts. The user must write configuration registers
// over APB only while the pipeline is empty; the block itself does not
// enforce this. The datapath samples them at several stages.
module energy_swingup_torque_select
#(
    parameter int COS_TABLE_BITS = 8,
    parameter int ANGLE_BITS     = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ests_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    ests_in_if.sink                           in_ch,
    ests_out_if.source                        out_ch
);

    localparam int AB       = ANGLE_BITS;
    localparam int IDXW     = COS_TABLE_BITS + 1;
    localparam int TBL_MAX  = 1 << COS_TABLE_BITS;
    localparam int SHIFT    = ANGLE_BITS - 2 - COS_TABLE_BITS;
    localparam int SHR      = (SHIFT > 0) ? SHIFT : 0;
    localparam int SHL      = (SHIFT < 0) ? -SHIFT : 0;
    localparam int RND      = (SHIFT > 0) ? (1 << (SHR - 1)) : 0;
    localparam int IW       = ANGLE_BITS + 3;
    localparam logic [AB-1:0] HALF    = AB'(1) << (AB - 1);
    localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);

    ests_pkg::cfg_t cfg;

    ests_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Global advance: move every stage whenever the output register is free
    // or being drained this cycle.
    logic out_valid_reg;
    logic advance;

    assign advance     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = advance;

    // ---------------- Stage 1: fold angle around upright, build index ----
    logic [31:0]   angle_ext;
    logic [AB-1:0] angle;
    logic [AB-1:0] rel;
    logic [AB-1:0] mag;
    logic [AB-1:0] arg;
    logic          far;
    logic          near;
    logic [IW-1:0] idx_wide;
    logic [IDXW-1:0] idx_next;

    assign angle_ext = 32'(in_ch.pend_angle);
    assign angle     = angle_ext[AB-1:0];
    assign rel       = angle - HALF;
    assign mag       = rel[AB-1] ? (AB'(0) - rel) : rel;
    assign near      = 32'(mag) < 32'(cfg.switch_threshold);
    assign far       = mag > QUARTER;
    // Past a quarter turn, look up the supplement and negate later.
    assign arg       = far ? (HALF - mag) : mag;
    assign idx_wide  = ((IW'(arg) + IW'(RND)) >> SHR) << SHL;
    assign idx_next  = (idx_wide > IW'(TBL_MAX)) ? IDXW'(TBL_MAX) : idx_wide[IDXW-1:0];

    logic                valid1_reg;
    logic [IDXW-1:0]     idx1_reg;
    logic                far1_reg;
    logic                near1_reg;
    logic signed [15:0]  rate1_reg;
    logic signed [15:0]  bal1_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            idx1_reg  <= idx_next;
            far1_reg  <= far;
            near1_reg <= near;
            rate1_reg <= in_ch.pend_rate;
            bal1_reg  <= in_ch.balance_torque;
        end
    end

    // ---------------- Stage 2: cosine ROM read, rate squared ------------
    logic [14:0] cos_mag2;

    ests_cos_rom #(.COS_TABLE_BITS(COS_TABLE_BITS)) u_cos_rom
    (
        .clk     (clk),
        .en      (advance),
        .idx     (idx1_reg),
        .cos_mag (cos_mag2)
    );

    logic [16:0] rate_ext;
    logic [16:0] rate_abs;
    logic [31:0] wsq_next;

    assign rate_ext = {rate1_reg[15], rate1_reg};
    assign rate_abs = rate1_reg[15] ? (17'd0 - rate_ext) : rate_ext;
    assign wsq_next = 32'(rate_abs[15:0]) * 32'(rate_abs[15:0]);

    logic                valid2_reg;
    logic                far2_reg;
    logic                near2_reg;
    logic signed [15:0]  rate2_reg;
    logic signed [15:0]  bal2_reg;
    logic [31:0]         wsq2_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            far2_reg  <= far1_reg;
            near2_reg <= near1_reg;
            rate2_reg <= rate1_reg;
            bal2_reg  <= bal1_reg;
            wsq2_reg  <= wsq_next;
        end
    end

    // ---------------- Stage 3: energy products and pump sign ------------
    logic signed [15:0] cos_s;
    logic [16:0]        one_minus;
    logic [47:0]        lhs_next;
    logic [31:0]        rhs_next;
    logic               neg_next;

    assign cos_s     = far2_reg ? (16'sd0 - $signed({1'b0, cos_mag2}))
                                : $signed({1'b0, cos_mag2});
    assign one_minus = 17'(ests_pkg::COS_ONE_Q14) - 17'(cos_s);
    assign lhs_next  = 48'(cfg.pend_length) * 48'(wsq2_reg);
    assign rhs_next  = 32'(cfg.gravity) * 32'(one_minus[15:0]);
    // Sign of rate times cosine; only strictly negative products flip.
    assign neg_next  = ((rate2_reg > 16'sd0) && (cos_s < 16'sd0))
                    || ((rate2_reg < 16'sd0) && (cos_s > 16'sd0));

    logic                valid3_reg;
    logic                near3_reg;
    logic                neg3_reg;
    logic signed [15:0]  bal3_reg;
    logic [47:0]         lhs3_reg;
    logic [31:0]         rhs3_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            near3_reg <= near2_reg;
            neg3_reg  <= neg_next;
            bal3_reg  <= bal2_reg;
            lhs3_reg  <= lhs_next;
            rhs3_reg  <= rhs_next;
        end
    end

    // ---------------- Stage 4: exact energy compare, torque select ------
    logic               pump;
    logic signed [15:0] torque_next;
    ests_pkg::mode_t    mode_next;

    assign pump = (cfg.pend_mass != 16'd0) && (cfg.pend_length != 16'd0)
               && (lhs3_reg < {5'd0, rhs3_reg, 11'd0});

    always_comb
    begin
        if (near3_reg)
        begin
            torque_next = bal3_reg;
            mode_next   = ests_pkg::MODE_BALANCE;
        end
        else if (pump)
        begin
            torque_next = neg3_reg ? $signed(16'd0 - {1'b0, cfg.torque_limit})
                                   : $signed({1'b0, cfg.torque_limit});
            mode_next   = ests_pkg::MODE_PUMP;
        end
        else
        begin
            torque_next = cfg.coast_torque;
            mode_next   = ests_pkg::MODE_COAST;
        end
    end

    logic signed [15:0] torque_reg;
    ests_pkg::mode_t    mode_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            torque_reg <= torque_next;
            mode_reg   <= mode_next;
        end
    end

    // Valid bits travel with the data; clear on reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg    <= 1'b0;
            valid2_reg    <= 1'b0;
            valid3_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid1_reg    <= in_ch.valid;
            valid2_reg    <= valid1_reg;
            valid3_reg    <= valid2_reg;
            out_valid_reg <= valid3_reg;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.drive_torque = torque_reg;
    assign out_ch.mode         = mode_reg;

endmodule

FILE: src/ests_checker.sv
// Port-level checker for the torque selector and its bind to the top level.
// Depends on ests_pkg and energy_swingup_torque_select.
module ests_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic signed [15:0]   in_balance_torque,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic signed [15:0]   out_drive_torque,
    input ests_pkg::mode_t      out_mode
);

    logic in_acc;

    assign in_acc = in_valid && in_ready;

    // Input side is free exactly when the output word is absent or drained.
    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not track output stall");

    // Without stalls an accepted word reaches the output.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("accepted word did not reach the output");

    // Passthrough words carry the regulator torque of the matching accepted word when no stall came between.
    a_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc ##1 out_ready ##1 out_ready ##1 out_ready
        ##1 (out_valid && out_mode == ests_pkg::MODE_BALANCE)
        |-> out_drive_torque == $past(in_balance_torque, 4))
        else $error("passthrough torque mismatch");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_drive_torque)
        && $stable(out_mode))
        else $error("stalled output word changed");

endmodule

bind energy_swingup_torque_select ests_checker u_ests_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_balance_torque (in_ch.balance_torque),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_drive_torque  (out_ch.drive_torque),
    .out_mode          (out_ch.mode)
);

FILE: verif/energy_swingup_torque_select_test.sv
// Self-checking testbench for the energy swing-up torque selector: drives sample
// words with bursty valid and a stalling output ready, predicts every torque word.
// Depends on ests_pkg, ests_if and the energy_swingup_torque_select RTL.
module energy_swingup_torque_select_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Quarter-wave cosine table geometry for the default block parameters
    // (8 table bits, 16 angle bits): 257 entries, index = angle >> 6 rounded.
    localparam int          TBL_LAST     = 256;
    localparam int          INDEX_SHIFT  = 6;
    localparam logic [15:0] HALF_TURN    = 16'h8000;
    localparam logic [15:0] QUARTER_TURN = 16'h4000;
    localparam longint      Q30_ONE      = 64'sd1 << 30;
    localparam longint      HALF_PI_Q30R = 64'sd1686629713;

    typedef struct packed {
        logic [15:0]        angle;
        logic signed [15:0] rate;
        logic signed [15:0] torque;
    } sample_word_t;

    typedef struct packed {
        logic signed [15:0] drive;
        ests_pkg::mode_t    mode;
    } torque_word_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ests_pkg::APB_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ests_in_if  in_ch ();
    ests_out_if out_ch ();

    energy_swingup_torque_select u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always #5 clk = ~clk;

    // Testbench image of the register file, the cosine table and the two queues:
    // sample words waiting for the driver, torque words waiting for the block.
    ests_pkg::cfg_t reg_image;
    int           cos_q14 [0:TBL_LAST];
    sample_word_t pending_words[$];
    torque_word_t expected_torques[$];
    sample_word_t on_bus;
    torque_word_t oldest_torque;
    int           mismatch_count = 0;
    int           burst_left     = 1;
    int           gap_left       = 0;
    int unsigned  stall_cycle    = 0;

    // Cosine of idx * (pi/2) / 256 in Q1.14: Q30 Taylor series evaluated from the
    // highest term down (divisors 12*11, 10*9, ... 2*1), rounded half up.
    function automatic int cos_q14_entry(input int unsigned idx);
        longint ang;
        longint ang_sq;
        longint acc;
        int     k;
        ang    = (longint'(idx) * HALF_PI_Q30R) >>> 8;
        ang_sq = (ang * ang) / Q30_ONE;
        acc    = Q30_ONE;
        for (k = 0; k < 6; k++)
        begin
            acc = Q30_ONE - ((ang_sq * acc) / Q30_ONE) / longint'((12 - 2 * k) * (11 - 2 * k));
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        if (acc > Q30_ONE)
        begin
            acc = Q30_ONE;
        end
        return int'((acc + 64'sd32768) / 64'sd65536);
    endfunction

    // Scale a folded angle magnitude to the table, rounding half up.
    function automatic int cos_index(input int unsigned mag);
        int unsigned idx;
        idx = (mag + (1 << (INDEX_SHIFT - 1))) >> INDEX_SHIFT;
        if (idx > TBL_LAST)
        begin
            idx = TBL_LAST;
        end
        return int'(idx);
    endfunction

    // Torque selection for one sample word under the current register image.
    function automatic torque_word_t select_torque(input sample_word_t s);
        logic [15:0]  rel;
        logic [15:0]  mag;
        int           cosv;
        int           rate;
        longint       rate_abs;
        longint       kinetic;
        longint       potential;
        logic         pump_down;
        torque_word_t r;
        // Fold the angle to upright-relative and take its magnitude; a half turn
        // away from upright folds to 0x8000 and stays there.
        rel = s.angle - HALF_TURN;
        mag = rel[15] ? 16'(-rel) : rel;
        if (mag < {1'b0, reg_image.switch_threshold})
        begin
            r.drive = s.torque;
            r.mode  = ests_pkg::MODE_BALANCE;
        end
        else
        begin
            if (mag <= QUARTER_TURN)
            begin
                cosv = cos_q14[cos_index(mag)];
            end
            else
            begin
                cosv = -cos_q14[cos_index(HALF_TURN - mag)];
            end
            rate     = s.rate;
            rate_abs = (rate < 0) ? longint'(-rate) : longint'(rate);
            // Exact energy compare: L*w^2 against G*(1 - cos) scaled to match.
            kinetic   = longint'(reg_image.pend_length) * rate_abs * rate_abs;
            potential = (longint'(reg_image.gravity) * longint'(16384 - cosv)) << 11;
            if (reg_image.pend_mass != 0 && reg_image.pend_length != 0 && kinetic < potential)
            begin
                pump_down = (rate > 0 && cosv < 0) || (rate < 0 && cosv > 0);
                r.drive   = pump_down ? -{1'b0, reg_image.torque_limit}
                                      : {1'b0, reg_image.torque_limit};
                r.mode    = ests_pkg::MODE_PUMP;
            end
            else
            begin
                r.drive = reg_image.coast_torque;
                r.mode  = ests_pkg::MODE_COAST;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40)
        begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // Sender: hold each word until accepted, predict its torque word at the
    // accepting edge, and insert random gaps between bursts of random length.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_torques.push_back(select_torque(on_bus));
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (gap_left > 0 || pending_words.size() == 0)
                begin
                    in_ch.valid <= 1'b0;
                    if (gap_left > 0)
                    begin
                        gap_left--;
                    end
                end
                else
                begin
                    on_bus = pending_words.pop_front();
                    in_ch.valid          <= 1'b1;
                    in_ch.pend_angle     <= on_bus.angle;
                    in_ch.pend_rate      <= on_bus.rate;
                    in_ch.balance_torque <= on_bus.torque;
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        // A third of the bursts run straight into the next one.
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
            end
        end
    end

    // Receiver: check each accepted torque word against the oldest prediction,
    // and stall on a pattern that steps through six phases in turn.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_torques.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word drive=%0d mode=%0d",
                                              out_ch.drive_torque, out_ch.mode));
                end
                else
                begin
                    oldest_torque = expected_torques.pop_front();
                    if (out_ch.drive_torque !== oldest_torque.drive)
                    begin
                        report_mismatch($sformatf("drive_torque %0d, expected %0d",
                                                  out_ch.drive_torque, oldest_torque.drive));
                    end
                    if (out_ch.mode !== oldest_torque.mode)
                    begin
                        report_mismatch($sformatf("mode %0d, expected %0d",
                                                  out_ch.mode, oldest_torque.mode));
                    end
                end
            end
            stall_cycle++;
            case ((stall_cycle >> 6) % 6)
                0, 1:    out_ch.ready <= 1'b1;
                2:       out_ch.ready <= $urandom_range(0, 1);
                3:       out_ch.ready <= (stall_cycle % 5) < 3;
                4:       out_ch.ready <= (stall_cycle % 8) == 0;
                default: out_ch.ready <= $urandom_range(0, 3) != 0;
            endcase
        end
    end

    // Write one register over APB, then read it back. Advance the register image
    // at the edge where the write lands; only the register's own width is kept.
    task automatic program_reg(input ests_pkg::reg_idx_t idx, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] field;
        mask  = (idx == ests_pkg::REG_TORQUE_LIM || idx == ests_pkg::REG_SWITCH_THR)
              ? 32'h7FFF : 32'hFFFF;
        field = value & mask;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            ests_pkg::REG_GRAVITY:     reg_image.gravity          = field[15:0];
            ests_pkg::REG_PEND_MASS:   reg_image.pend_mass        = field[15:0];
            ests_pkg::REG_PEND_LENGTH: reg_image.pend_length      = field[15:0];
            ests_pkg::REG_TORQUE_LIM:  reg_image.torque_limit     = field[14:0];
            ests_pkg::REG_SWITCH_THR:  reg_image.switch_threshold = field[14:0];
            default:                   reg_image.coast_torque     = field[15:0];
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if ((prdata & mask) !== field)
        begin
            report_mismatch($sformatf("register %0d reads 0x%0h, expected 0x%0h",
                                      idx, prdata & mask, field));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_all(input int grav, input int mass, input int len,
                               input int tlim, input int thr, input int coast);
        program_reg(ests_pkg::REG_GRAVITY, 32'(grav));
        program_reg(ests_pkg::REG_PEND_MASS, 32'(mass));
        program_reg(ests_pkg::REG_PEND_LENGTH, 32'(len));
        program_reg(ests_pkg::REG_TORQUE_LIM, 32'(tlim));
        program_reg(ests_pkg::REG_SWITCH_THR, 32'(thr));
        program_reg(ests_pkg::REG_COAST_TRQ, 32'(coast) & 32'hFFFF);
    endtask

    task automatic queue_word(input int angle, input int rate, input int torque);
        sample_word_t s;
        s.angle  = 16'(angle);
        s.rate   = 16'(rate);
        s.torque = 16'(torque);
        pending_words.push_back(s);
    endtask

    // Random words: angles cluster at the switch threshold, at the half turn
    // and at the quarter turns; rates mix full range, small values and extremes.
    task automatic queue_random(input int count);
        int n;
        int thr;
        int angle;
        int rate;
        for (n = 0; n < count; n++)
        begin
            thr = reg_image.switch_threshold;
            case ($urandom_range(0, 4))
                0, 1: angle = $urandom_range(0, 65535);
                2:    angle = ($urandom_range(0, 1) ? 32768 + thr : 32768 - thr)
                              + $urandom_range(0, 6) - 3;
                3:    angle = $urandom_range(0, 40) - 20;
                default:
                    angle = ($urandom_range(0, 1) ? 16384 : 49152) + $urandom_range(0, 80) - 40;
            endcase
            case ($urandom_range(0, 4))
                0, 1, 2: rate = $urandom_range(0, 65535);
                3:       rate = $urandom_range(0, 1200) - 600;
                default:
                begin
                    case ($urandom_range(0, 4))
                        0:       rate = -32768;
                        1:       rate = 32767;
                        2:       rate = -1;
                        3:       rate = 1;
                        default: rate = 0;
                    endcase
                end
            endcase
            queue_word(angle, rate, $urandom_range(0, 65535));
        end
    endtask

    // Sample at the falling edge so the driver's pushes at the rising edge are done.
    task automatic wait_for_idle();
        do @(negedge clk);
        while (pending_words.size() != 0 || in_ch.valid || expected_torques.size() != 0);
    endtask

    initial
    begin
        int i;
        int p;
        for (i = 0; i <= TBL_LAST; i++)
        begin
            cos_q14[i] = cos_q14_entry(i);
        end
        reg_image = '{gravity: ests_pkg::RST_GRAVITY,
                      pend_mass: ests_pkg::RST_PEND_MASS,
                      pend_length: ests_pkg::RST_PEND_LENGTH,
                      torque_limit: ests_pkg::RST_TORQUE_LIM,
                      switch_threshold: ests_pkg::RST_SWITCH_THR,
                      coast_torque: ests_pkg::RST_COAST_TRQ};
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        in_ch.valid          = 1'b0;
        in_ch.pend_angle     = '0;
        in_ch.pend_rate      = '0;
        in_ch.balance_torque = '0;
        out_ch.ready         = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words under the reset registers. Cover upright and the
        // switch threshold edges, the half turn away from upright (cosine -1),
        // both quarter turns, zero rate, and both pump directions.
        queue_word(32768, 0, -32768);
        queue_word(32768 + 7300, 32767, 32767);
        queue_word(32768 - 7300, -32768, 0);
        queue_word(32768 + 7301, 100, 1);
        queue_word(32768 - 7301, -100, -1);
        queue_word(0, 0, 0);
        queue_word(0, 1, 0);
        queue_word(0, -1, 0);
        queue_word(0, 32767, 0);
        queue_word(0, -32768, 0);
        queue_word(16384, 500, 4321);
        queue_word(49152, -500, -4321);
        queue_word(16383, 200, 0);
        queue_word(16385, -200, 0);
        queue_word(65535, 1000, 1);
        queue_word(1, -1000, -1);
        queue_word(32768 + 8000, 300, 0);
        queue_word(32768 - 8000, -300, 0);
        queue_word(32768 + 8000, 32767, 0);
        queue_word(65535, 32767, 32767);
        queue_word(20000, -2000, 12345);
        queue_random(60);
        wait_for_idle();

        // All registers at their maximum: almost everything is near upright.
        program_all(65535, 65535, 65535, 32767, 32767, 32767);
        queue_random(50);
        wait_for_idle();

        // All registers at their minimum: zero mass and length force coasting.
        program_all(0, 0, 0, 0, 0, -32768);
        queue_random(40);
        wait_for_idle();

        // Light, short pendulum under strong gravity: mostly pumping.
        program_all(65535, 1, 1, 1, 0, -1);
        queue_random(60);
        wait_for_idle();

        // Zero length alone still forces the coast branch.
        program_reg(ests_pkg::REG_PEND_LENGTH, 32'd0);
        program_reg(ests_pkg::REG_SWITCH_THR, 32'd3000);
        queue_random(30);
        wait_for_idle();

        // Random register settings.
        for (p = 0; p < 3; p++)
        begin
            program_all($urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 32767),
                        $urandom_range(0, 12000), $urandom_range(0, 65535));
            queue_random(50);
            wait_for_idle();
        end

        // Drain: let any stray word surface past the four-stage pipeline.
        repeat (12) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: energy_swingup_torque_select.f
src/ests_pkg.sv
src/ests_if.sv
src/ests_regs.sv
src/ests_cos_rom.sv
src/energy_swingup_torque_select.sv
src/ests_checker.sv
verif/energy_swingup_torque_select_test.sv
